FILE: hw/rtl/lob_pkg.sv
package lob_pkg;

    // Book geometry and field widths
    localparam int BOOK_DEPTH = 32;
    localparam int PRICE_BITS = 16;
    localparam int QTY_BITS   = 16;
    localparam int MAX_FILLS  = 32;

    localparam int IDX_W  = $clog2(BOOK_DEPTH);
    localparam int CNT_W  = $clog2(BOOK_DEPTH + 1);
    localparam int FILL_W = $clog2(MAX_FILLS + 1);

    // Order side codes
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Book select codes (bid book is where buys rest)
    localparam logic BOOK_BID = 1'b0;
    localparam logic BOOK_ASK = 1'b1;

    // Rest status codes
    localparam logic [1:0] ST_FILLED  = 2'd0;
    localparam logic [1:0] ST_RESTED  = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic                  side;
        logic [QTY_BITS-1:0]   qty;
        logic [PRICE_BITS-1:0] limit_price;
    } order_t;

    typedef struct packed {
        logic [QTY_BITS-1:0]   fill_qty;
        logic [PRICE_BITS-1:0] fill_price;
        logic [1:0]            rest_status;
        logic [QTY_BITS-1:0]   remaining_qty;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } entry_t;

    // Sequencer command to the book; offsets count from each side's head
    typedef struct packed {
        logic             rd_en;
        logic             rd_book;
        logic [IDX_W-1:0] rd_off;
        logic             wr_en;
        logic             wr_book;
        logic [IDX_W-1:0] wr_off;
        entry_t           wr_entry;
        logic             pop;
        logic             pop_book;
        logic             push;
        logic             push_book;
    } book_cmd_t;

endpackage

FILE: hw/rtl/lob_book.sv
module lob_book
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lob_pkg::book_cmd_t                     cmd,
    output lob_pkg::entry_t                        rd_entry,
    output logic [1:0][lob_pkg::CNT_W-1:0]         count
);

    // Both sides live in one memory, each as a circular buffer
    lob_pkg::entry_t mem [2][lob_pkg::BOOK_DEPTH];

    logic [1:0][lob_pkg::IDX_W-1:0] head_reg;
    logic [1:0][lob_pkg::IDX_W-1:0] head_next;
    logic [1:0][lob_pkg::CNT_W-1:0] count_reg;
    logic [1:0][lob_pkg::CNT_W-1:0] count_next;
    lob_pkg::entry_t                rd_entry_reg;
    logic [lob_pkg::IDX_W-1:0]      rd_idx;
    logic [lob_pkg::IDX_W-1:0]      wr_idx;

    // Map an offset from the head onto a physical slot
    function automatic logic [lob_pkg::IDX_W-1:0] phys_idx(
        input logic [lob_pkg::IDX_W-1:0] head,
        input logic [lob_pkg::IDX_W-1:0] off
    );
        logic [lob_pkg::IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (lob_pkg::IDX_W + 1)'(lob_pkg::BOOK_DEPTH))
        begin
            sum = sum - (lob_pkg::IDX_W + 1)'(lob_pkg::BOOK_DEPTH);
        end
        return sum[lob_pkg::IDX_W-1:0];
    endfunction

    assign rd_idx   = phys_idx(head_reg[cmd.rd_book], cmd.rd_off);
    assign wr_idx   = phys_idx(head_reg[cmd.wr_book], cmd.wr_off);
    assign rd_entry = rd_entry_reg;
    assign count    = count_reg;

    // Advance the head and shrink the count on a pop, grow the count on a push
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            if (head_reg[cmd.pop_book] == lob_pkg::IDX_W'(lob_pkg::BOOK_DEPTH - 1))
            begin
                head_next[cmd.pop_book] = '0;
            end
            else
            begin
                head_next[cmd.pop_book] = head_reg[cmd.pop_book] + lob_pkg::IDX_W'(1);
            end
            count_next[cmd.pop_book] = count_reg[cmd.pop_book] - lob_pkg::CNT_W'(1);
        end
        if (cmd.push)
        begin
            count_next[cmd.push_book] = count_reg[cmd.push_book] + lob_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_book][wr_idx] <= cmd.wr_entry;
        end
        if (cmd.rd_en)
        begin
            rd_entry_reg <= mem[cmd.rd_book][rd_idx];
        end
    end

endmodule

FILE: hw/rtl/limit_order_book_matcher_top.sv
// Limit order book matcher, price-time priority. Raise start with an order while busy is low;
// the order is taken at that edge and busy stays high until the cycle that carries its final
// result. Each result appears on result for one cycle with result_valid high and cannot be held
// off, so the receiver must take it at once; the final result of an order has last set and
// carries the rest status. For each fill an order reads and trades against the opposite head;
// for each resting entry moved back to make room for the remainder it reads that entry and
// writes it one slot back; the remainder is placed after a priority compare when the opposite
// head does not cross. Every step goes through the single port pair of the book memory, whose
// read is registered. The book starts empty after reset and needs no clearing pass.
module limit_order_book_matcher_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lob_pkg::order_t  order,
    output logic             busy,
    output logic             result_valid,
    output lob_pkg::result_t result
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD       = 3'd1;
    localparam logic [2:0] S_EVAL     = 3'd2;
    localparam logic [2:0] S_REST     = 3'd3;
    localparam logic [2:0] S_INS_RD   = 3'd4;
    localparam logic [2:0] S_INS_EVAL = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]                        state_reg, state_next;
    logic                              side_reg, side_next;
    logic [lob_pkg::PRICE_BITS-1:0]    limit_reg, limit_next;
    logic [lob_pkg::QTY_BITS-1:0]      remaining_reg, remaining_next;
    logic [lob_pkg::FILL_W-1:0]        fills_reg, fills_next;
    logic [1:0]                        status_reg, status_next;
    logic                              pend_valid_reg, pend_valid_next;
    lob_pkg::result_t                  pend_reg, pend_next;
    logic [lob_pkg::IDX_W-1:0]         ins_off_reg, ins_off_next;
    logic                              res_valid_reg, res_valid_next;
    lob_pkg::result_t                  res_reg, res_next;

    lob_pkg::book_cmd_t                cmd;
    lob_pkg::entry_t                   rd_entry;
    logic [1:0][lob_pkg::CNT_W-1:0]    book_count;

    logic                              opp_book;
    logic                              own_book;
    logic                              crosses;
    logic                              worse;
    logic [lob_pkg::QTY_BITS-1:0]      take;
    lob_pkg::entry_t                   new_entry;

    lob_book u_book
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_entry (rd_entry),
        .count    (book_count)
    );

    // A buy rests in the bid book and trades against the ask book
    assign own_book  = (side_reg == lob_pkg::SIDE_BUY) ? lob_pkg::BOOK_BID : lob_pkg::BOOK_ASK;
    assign opp_book  = ~own_book;
    assign new_entry = '{price: limit_reg, qty: remaining_reg};

    // Compare logic on the read entry: crossing test on the opposite head, priority test while inserting
    assign crosses = (side_reg == lob_pkg::SIDE_BUY) ? (limit_reg >= rd_entry.price)
                                                     : (limit_reg <= rd_entry.price);
    assign worse   = (side_reg == lob_pkg::SIDE_BUY) ? (rd_entry.price < limit_reg)
                                                     : (rd_entry.price > limit_reg);
    assign take    = (remaining_reg < rd_entry.qty) ? remaining_reg : rd_entry.qty;

    // Sequence matching, resting and the final transfer
    always_comb
    begin
        state_next      = state_reg;
        side_next       = side_reg;
        limit_next      = limit_reg;
        remaining_next  = remaining_reg;
        fills_next      = fills_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ins_off_next    = ins_off_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        cmd             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    side_next       = order.side;
                    limit_next      = order.limit_price;
                    remaining_next  = order.qty;
                    fills_next      = '0;
                    status_next     = lob_pkg::ST_FILLED;
                    pend_valid_next = 1'b0;
                    state_next      = S_RD;
                end
            end

            S_RD:
            begin
                if (remaining_reg == '0)
                begin
                    status_next = lob_pkg::ST_FILLED;
                    state_next  = S_DONE;
                end
                else if (book_count[opp_book] == '0)
                begin
                    state_next = S_REST;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_book = opp_book;
                    cmd.rd_off  = '0;
                    state_next  = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (!crosses)
                begin
                    state_next = S_REST;
                end
                else if (fills_reg == lob_pkg::FILL_W'(lob_pkg::MAX_FILLS))
                begin
                    // Fill limit reached while still crossing: drop the remainder
                    status_next = lob_pkg::ST_DROPPED;
                    state_next  = S_DONE;
                end
                else
                begin
                    // Trade against the head; pop it if used up, else shrink it
                    if (take == rd_entry.qty)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.pop_book = opp_book;
                    end
                    else
                    begin
                        cmd.wr_en        = 1'b1;
                        cmd.wr_book      = opp_book;
                        cmd.wr_off       = '0;
                        cmd.wr_entry     = '{price: rd_entry.price, qty: rd_entry.qty - take};
                    end
                    // Transfer the previous fill, hold this one until its last flag is known
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = pend_reg;
                    end
                    remaining_next  = remaining_reg - take;
                    pend_valid_next = 1'b1;
                    pend_next       = '{fill_qty:      take,
                                        fill_price:    rd_entry.price,
                                        rest_status:   lob_pkg::ST_FILLED,
                                        remaining_qty: remaining_reg - take,
                                        last:          1'b0};
                    fills_next      = fills_reg + lob_pkg::FILL_W'(1);
                    state_next      = S_RD;
                end
            end

            S_REST:
            begin
                if (book_count[own_book] == lob_pkg::CNT_W'(lob_pkg::BOOK_DEPTH))
                begin
                    status_next = lob_pkg::ST_DROPPED;
                    state_next  = S_DONE;
                end
                else
                begin
                    ins_off_next = book_count[own_book][lob_pkg::IDX_W-1:0];
                    state_next   = S_INS_RD;
                end
            end

            S_INS_RD:
            begin
                if (ins_off_reg == '0)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_book   = own_book;
                    cmd.wr_off    = '0;
                    cmd.wr_entry  = new_entry;
                    cmd.push      = 1'b1;
                    cmd.push_book = own_book;
                    status_next   = lob_pkg::ST_RESTED;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_book = own_book;
                    cmd.rd_off  = ins_off_reg - lob_pkg::IDX_W'(1);
                    state_next  = S_INS_EVAL;
                end
            end

            S_INS_EVAL:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_book = own_book;
                cmd.wr_off  = ins_off_reg;
                if (worse)
                begin
                    // Move the lower-priority entry back one slot
                    cmd.wr_entry = rd_entry;
                    ins_off_next = ins_off_reg - lob_pkg::IDX_W'(1);
                    state_next   = S_INS_RD;
                end
                else
                begin
                    cmd.wr_entry  = new_entry;
                    cmd.push      = 1'b1;
                    cmd.push_book = own_book;
                    status_next   = lob_pkg::ST_RESTED;
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                res_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    res_next             = pend_reg;
                    res_next.rest_status = status_reg;
                    res_next.last        = 1'b1;
                end
                else
                begin
                    res_next = '{fill_qty:      '0,
                                 fill_price:    '0,
                                 rest_status:   status_reg,
                                 remaining_qty: remaining_reg,
                                 last:          1'b1};
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            fills_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            fills_reg      <= fills_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        side_reg      <= side_next;
        limit_reg     <= limit_next;
        remaining_reg <= remaining_next;
        status_reg    <= status_next;
        pend_reg      <= pend_next;
        ins_off_reg   <= ins_off_next;
        res_reg       <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Every order ends with exactly one last transfer as the block goes idle
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (result_valid && result.last && !busy))
        else $error("final transfer missing after order completion");

    // Intermediate fills never carry a rest status
    a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (result.rest_status == lob_pkg::ST_FILLED))
        else $error("non-final transfer carries a rest status");

    // A side never holds more entries than the book depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (book_count[0] <= lob_pkg::CNT_W'(lob_pkg::BOOK_DEPTH))
        && (book_count[1] <= lob_pkg::CNT_W'(lob_pkg::BOOK_DEPTH)))
        else $error("book side count exceeds depth");

    // A non-final fill always leaves quantity open
    a_mid_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (result.remaining_qty != '0))
        else $error("non-final transfer with nothing remaining");

endmodule
